FILE: design/ptts_pkg.sv
package ptts_pkg;

    // Default build of the scheduler
    localparam int SLOTS_DEF       = 8;
    localparam int TICK_LENGTH_DEF = 10;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int TGT_W    = 4;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int PEND_W   = 8;

    // Dispatch emits at most this many results per request
    localparam int MAX_RESULTS = 8;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Reciprocal multiply takes one 16-bit digit of each time per step
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_STEPS   = TIME_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_TICK     = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_DELETE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED       = 3'd0,
        ST_FULL        = 3'd1,
        ST_RUN         = 3'd2,
        ST_NONE_READY  = 3'd3,
        ST_DELETED     = 3'd4,
        ST_DEL_IGNORED = 3'd5,
        ST_TICK_DONE   = 3'd6
    } t_status;

    // One task slot as held in the slot memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [PEND_W-1:0]   pending;
    } t_slot_rec;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE       = 4'd0,
        OP_CAPTURE    = 4'd1,
        OP_DIV        = 4'd2,
        OP_ADD        = 4'd3,
        OP_FULL       = 4'd4,
        OP_TICK_SLOT  = 4'd5,
        OP_TICK_DONE  = 4'd6,
        OP_DISP_SLOT  = 4'd7,
        OP_NONE_READY = 4'd8,
        OP_DELETE     = 4'd9
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  out_free;
        logic  div_done;
        logic  idx_last;
        logic  add_ok;
        logic  slot_ready;
        logic  more_ready;
        logic  res_last;
    } t_dp_sts;

    typedef enum logic [3:0] {
        S_IDLE       = 4'd0,
        S_DECODE     = 4'd1,
        S_DIV        = 4'd2,
        S_ADD        = 4'd3,
        S_FULL       = 4'd4,
        S_TICK_UPD   = 4'd5,
        S_TICK_RD    = 4'd6,
        S_TICK_DONE  = 4'd7,
        S_DISP_UPD   = 4'd8,
        S_DISP_RD    = 4'd9,
        S_NONE_READY = 4'd10,
        S_DELETE     = 4'd11
    } t_ctrl_state;

endpackage

FILE: design/ptts_in_if.sv
interface ptts_in_if;
    logic                            valid;
    logic                            ready;
    logic [ptts_pkg::MODE_W-1:0]     mode;
    logic [ptts_pkg::HANDLE_W-1:0]   handle;
    logic [ptts_pkg::TIME_W-1:0]     delay_time;
    logic [ptts_pkg::TIME_W-1:0]     period_time;
    logic [ptts_pkg::TGT_W-1:0]      target_slot;

    modport source (
        output valid, mode, handle, delay_time, period_time, target_slot,
        input  ready
    );

    modport sink (
        input  valid, mode, handle, delay_time, period_time, target_slot,
        output ready
    );
endinterface

FILE: design/ptts_out_if.sv
interface ptts_out_if;
    logic                            valid;
    logic                            ready;
    logic [ptts_pkg::STATUS_W-1:0]   status;
    logic [ptts_pkg::SLOT_W-1:0]     slot;
    logic [ptts_pkg::HANDLE_W-1:0]   task_handle;
    logic                            last;

    modport source (
        output valid, status, slot, task_handle, last,
        input  ready
    );

    modport sink (
        input  valid, status, slot, task_handle, last,
        output ready
    );
endinterface

FILE: design/ptts_ctrl.sv
module ptts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptts_pkg::t_dp_sts i_sts,
    output ptts_pkg::t_dp_cmd o_cmd
);

    ptts_pkg::t_ctrl_state r_state;
    ptts_pkg::t_ctrl_state n_state;
    logic                  w_disp_end;

    // Dispatch stops after the result cap or when no later slot is ready
    assign w_disp_end = i_sts.res_last || !i_sts.more_ready;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ptts_pkg::S_DECODE;
            end
            ptts_pkg::S_DECODE: begin
                unique case (i_sts.mode)
                    ptts_pkg::MODE_ADD: begin
                        n_state = i_sts.add_ok ? ptts_pkg::S_DIV : ptts_pkg::S_FULL;
                    end
                    ptts_pkg::MODE_TICK:     n_state = ptts_pkg::S_TICK_UPD;
                    ptts_pkg::MODE_DISPATCH: n_state = ptts_pkg::S_DISP_UPD;
                    ptts_pkg::MODE_DELETE:   n_state = ptts_pkg::S_DELETE;
                    default:                 n_state = ptts_pkg::S_IDLE;
                endcase
            end
            ptts_pkg::S_DIV: begin
                if (i_sts.div_done) n_state = ptts_pkg::S_ADD;
            end
            ptts_pkg::S_ADD, ptts_pkg::S_FULL, ptts_pkg::S_TICK_DONE,
            ptts_pkg::S_NONE_READY, ptts_pkg::S_DELETE: begin
                if (i_sts.out_free) n_state = ptts_pkg::S_IDLE;
            end
            ptts_pkg::S_TICK_UPD: begin
                n_state = i_sts.idx_last ? ptts_pkg::S_TICK_DONE : ptts_pkg::S_TICK_RD;
            end
            ptts_pkg::S_TICK_RD: begin
                n_state = ptts_pkg::S_TICK_UPD;
            end
            ptts_pkg::S_DISP_UPD: begin
                if (i_sts.slot_ready) begin
                    if (i_sts.out_free) begin
                        n_state = w_disp_end ? ptts_pkg::S_IDLE : ptts_pkg::S_DISP_RD;
                    end
                end else begin
                    n_state = i_sts.idx_last ? ptts_pkg::S_NONE_READY
                                             : ptts_pkg::S_DISP_RD;
                end
            end
            ptts_pkg::S_DISP_RD: begin
                n_state = ptts_pkg::S_DISP_UPD;
            end
            default: n_state = ptts_pkg::S_IDLE;
        endcase
    end

    // Drive commands
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.op      = ptts_pkg::OP_IDLE;
        o_cmd.idx_inc = 1'b0;
        unique case (r_state)
            ptts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = ptts_pkg::OP_CAPTURE;
            end
            ptts_pkg::S_DIV: begin
                if (!i_sts.div_done) o_cmd.op = ptts_pkg::OP_DIV;
            end
            ptts_pkg::S_ADD: begin
                if (i_sts.out_free) o_cmd.op = ptts_pkg::OP_ADD;
            end
            ptts_pkg::S_FULL: begin
                if (i_sts.out_free) o_cmd.op = ptts_pkg::OP_FULL;
            end
            ptts_pkg::S_TICK_UPD: begin
                o_cmd.op      = ptts_pkg::OP_TICK_SLOT;
                o_cmd.idx_inc = !i_sts.idx_last;
            end
            ptts_pkg::S_TICK_DONE: begin
                if (i_sts.out_free) o_cmd.op = ptts_pkg::OP_TICK_DONE;
            end
            ptts_pkg::S_DISP_UPD: begin
                if (i_sts.slot_ready) begin
                    if (i_sts.out_free) begin
                        o_cmd.op      = ptts_pkg::OP_DISP_SLOT;
                        o_cmd.idx_inc = !w_disp_end;
                    end
                end else begin
                    o_cmd.idx_inc = !i_sts.idx_last;
                end
            end
            ptts_pkg::S_NONE_READY: begin
                if (i_sts.out_free) o_cmd.op = ptts_pkg::OP_NONE_READY;
            end
            ptts_pkg::S_DELETE: begin
                if (i_sts.out_free) o_cmd.op = ptts_pkg::OP_DELETE;
            end
            ptts_pkg::S_DECODE, ptts_pkg::S_TICK_RD, ptts_pkg::S_DISP_RD: begin
                o_cmd.op = ptts_pkg::OP_IDLE;
            end
            default: o_cmd.op = ptts_pkg::OP_IDLE;
        endcase
    end

endmodule

FILE: design/ptts_dp.sv
module ptts_dp #(
    parameter int SLOTS       = ptts_pkg::SLOTS_DEF,
    parameter int TICK_LENGTH = ptts_pkg::TICK_LENGTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptts_pkg::t_dp_cmd               i_cmd,
    output ptts_pkg::t_dp_sts               o_sts,
    input  logic [ptts_pkg::MODE_W-1:0]     i_in_mode,
    input  logic [ptts_pkg::HANDLE_W-1:0]   i_in_handle,
    input  logic [ptts_pkg::TIME_W-1:0]     i_in_delay_time,
    input  logic [ptts_pkg::TIME_W-1:0]     i_in_period_time,
    input  logic [ptts_pkg::TGT_W-1:0]      i_in_target_slot,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ptts_pkg::STATUS_W-1:0]   o_out_status,
    output logic [ptts_pkg::SLOT_W-1:0]     o_out_slot,
    output logic [ptts_pkg::HANDLE_W-1:0]   o_out_task_handle,
    output logic                            o_out_last
);

    localparam int                TW       = ptts_pkg::TIME_W;
    localparam int                DW       = ptts_pkg::DIV_DIGIT_W;
    localparam int                IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0]     LAST_IDX = IW'(SLOTS - 1);

    // x / TICK_LENGTH == (x * RECIP) >> (TW + SH) for every TW-bit x
    localparam int                SH       = $clog2(TICK_LENGTH);
    localparam int                MW       = TW + 1;
    localparam int                AW       = TW + MW;
    localparam logic [63:0]       RECIP_WIDE =
        ((64'd1 << (TW + SH)) + 64'(TICK_LENGTH) - 64'd1) / 64'(TICK_LENGTH);
    localparam logic [MW-1:0]     RECIP    = MW'(RECIP_WIDE);

    // Latched request
    ptts_pkg::t_mode                 r_mode;
    logic [ptts_pkg::HANDLE_W-1:0]   r_handle;
    logic [ptts_pkg::TGT_W-1:0]      r_tgt;

    // Divider lanes for delay and period
    logic [TW-1:0]                   r_dq;
    logic [TW-1:0]                   r_pq;
    logic [AW-1:0]                   r_dacc;
    logic [AW-1:0]                   r_pacc;
    logic [ptts_pkg::DIV_CNT_W-1:0]  r_dcnt;

    // Slot walk and table flags
    logic [IW-1:0]                   r_idx;
    logic                            r_add_ok;
    logic [ptts_pkg::RES_W-1:0]      r_nres;
    logic [SLOTS-1:0]                r_valid;
    logic [SLOTS-1:0]                r_ready;

    // Slot memory
    ptts_pkg::t_slot_rec             r_mem [SLOTS];
    ptts_pkg::t_slot_rec             r_rd;

    // Result register
    logic                            r_o_valid;
    ptts_pkg::t_status               r_o_status;
    logic [ptts_pkg::SLOT_W-1:0]     r_o_slot;
    logic [ptts_pkg::HANDLE_W-1:0]   r_o_handle;
    logic                            r_o_last;

    logic                            w_free_found;
    logic [IW-1:0]                   w_free_idx;
    logic                            w_more;
    logic [IW-1:0]                   w_del_idx;
    logic                            w_del_ok;
    logic                            w_res_last;
    logic [DW+MW-1:0]                w_dprod;
    logic [DW+MW-1:0]                w_pprod;
    logic [TW-1:0]                   w_dquo;
    logic [TW-1:0]                   w_pquo;
    ptts_pkg::t_slot_rec             w_rec_tick;
    ptts_pkg::t_slot_rec             w_rec_disp;
    ptts_pkg::t_slot_rec             w_rec_add;
    logic                            w_we;
    ptts_pkg::t_slot_rec             w_wrec;
    logic                            w_emit;
    ptts_pkg::t_status               w_emit_status;
    logic [ptts_pkg::SLOT_W-1:0]     w_emit_slot;
    logic [ptts_pkg::HANDLE_W-1:0]   w_emit_handle;
    logic                            w_emit_last;

    // Find the lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(j);
            end
        end
    end

    // Look for a ready slot above the current one
    always_comb begin
        w_more = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (r_ready[j] && (IW'(j) > r_idx)) w_more = 1'b1;
        end
    end

    assign w_del_idx  = IW'(r_tgt);
    assign w_del_ok   = (32'(r_tgt) < 32'(SLOTS)) && r_valid[w_del_idx];
    assign w_res_last = (r_nres == ptts_pkg::RES_W'(ptts_pkg::MAX_RESULTS - 1));

    // Multiply the top digit of each lane by the reciprocal
    assign w_dprod = r_dq[TW-1 -: DW] * RECIP;
    assign w_pprod = r_pq[TW-1 -: DW] * RECIP;
    assign w_dquo  = TW'(r_dacc >> (TW + SH));
    assign w_pquo  = TW'(r_pacc >> (TW + SH));

    // Age one slot on tick
    always_comb begin
        w_rec_tick = r_rd;
        if (r_rd.delay == '0) begin
            if (r_rd.pending != '1) w_rec_tick.pending = r_rd.pending + 1'b1;
            if (r_rd.period != '0) w_rec_tick.delay = r_rd.period;
        end else begin
            w_rec_tick.delay = r_rd.delay - 1'b1;
        end
    end

    // Consume one run on dispatch
    always_comb begin
        w_rec_disp         = r_rd;
        w_rec_disp.pending = r_rd.pending - 1'b1;
    end

    always_comb begin
        w_rec_add.handle  = r_handle;
        w_rec_add.delay   = w_dquo;
        w_rec_add.period  = w_pquo;
        w_rec_add.pending = '0;
    end

    // Select the memory write
    always_comb begin
        w_we   = 1'b0;
        w_wrec = w_rec_add;
        case (i_cmd.op)
            ptts_pkg::OP_ADD: begin
                w_we = 1'b1;
            end
            ptts_pkg::OP_TICK_SLOT: begin
                w_we   = r_valid[r_idx];
                w_wrec = w_rec_tick;
            end
            ptts_pkg::OP_DISP_SLOT: begin
                w_we   = (r_rd.period != '0);
                w_wrec = w_rec_disp;
            end
            default: w_we = 1'b0;
        endcase
    end

    // Build the result for this operation
    always_comb begin
        w_emit        = 1'b0;
        w_emit_status = ptts_pkg::ST_ADDED;
        w_emit_slot   = '0;
        w_emit_handle = '0;
        w_emit_last   = 1'b1;
        unique case (i_cmd.op)
            ptts_pkg::OP_ADD: begin
                w_emit      = 1'b1;
                w_emit_slot = ptts_pkg::SLOT_W'(r_idx);
            end
            ptts_pkg::OP_FULL: begin
                w_emit        = 1'b1;
                w_emit_status = ptts_pkg::ST_FULL;
            end
            ptts_pkg::OP_TICK_DONE: begin
                w_emit        = 1'b1;
                w_emit_status = ptts_pkg::ST_TICK_DONE;
            end
            ptts_pkg::OP_DISP_SLOT: begin
                w_emit        = 1'b1;
                w_emit_status = ptts_pkg::ST_RUN;
                w_emit_slot   = ptts_pkg::SLOT_W'(r_idx);
                w_emit_handle = r_rd.handle;
                w_emit_last   = w_res_last || !w_more;
            end
            ptts_pkg::OP_NONE_READY: begin
                w_emit        = 1'b1;
                w_emit_status = ptts_pkg::ST_NONE_READY;
            end
            ptts_pkg::OP_DELETE: begin
                w_emit = 1'b1;
                if (w_del_ok) begin
                    w_emit_status = ptts_pkg::ST_DELETED;
                    w_emit_slot   = ptts_pkg::SLOT_W'(r_tgt);
                end else begin
                    w_emit_status = ptts_pkg::ST_DEL_IGNORED;
                end
            end
            default: w_emit = 1'b0;
        endcase
    end

    // Control state: flags, walk index, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ready   <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
            r_nres    <= '0;
            r_dcnt    <= '0;
            r_add_ok  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
            case (i_cmd.op)
                ptts_pkg::OP_CAPTURE: begin
                    r_idx    <= (ptts_pkg::t_mode'(i_in_mode) == ptts_pkg::MODE_ADD)
                                ? w_free_idx : '0;
                    r_add_ok <= w_free_found;
                    r_nres   <= '0;
                    r_dcnt   <= '0;
                end
                ptts_pkg::OP_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ptts_pkg::OP_ADD: begin
                    r_valid[r_idx] <= 1'b1;
                    r_ready[r_idx] <= 1'b0;
                end
                ptts_pkg::OP_TICK_SLOT: begin
                    if (r_valid[r_idx] && (r_rd.delay == '0)) r_ready[r_idx] <= 1'b1;
                end
                ptts_pkg::OP_DISP_SLOT: begin
                    r_nres <= r_nres + 1'b1;
                    if (r_rd.period == '0) begin
                        r_valid[r_idx] <= 1'b0;
                        r_ready[r_idx] <= 1'b0;
                    end else begin
                        r_ready[r_idx] <= (r_rd.pending != ptts_pkg::PEND_W'(1));
                    end
                end
                ptts_pkg::OP_DELETE: begin
                    if (w_del_ok) begin
                        r_valid[w_del_idx] <= 1'b0;
                        r_ready[w_del_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: request, divider lanes, memory, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ptts_pkg::OP_CAPTURE) begin
            r_mode   <= ptts_pkg::t_mode'(i_in_mode);
            r_handle <= i_in_handle;
            r_tgt    <= i_in_target_slot;
            r_dq     <= i_in_delay_time;
            r_pq     <= i_in_period_time;
            r_dacc   <= '0;
            r_pacc   <= '0;
        end else if (i_cmd.op == ptts_pkg::OP_DIV) begin
            // Advance one digit: shift the sum up and add the next partial product
            r_dq   <= {r_dq[TW-DW-1:0], {DW{1'b0}}};
            r_pq   <= {r_pq[TW-DW-1:0], {DW{1'b0}}};
            r_dacc <= {r_dacc[AW-DW-1:0], {DW{1'b0}}} + AW'(w_dprod);
            r_pacc <= {r_pacc[AW-DW-1:0], {DW{1'b0}}} + AW'(w_pprod);
        end
        r_rd <= r_mem[r_idx];
        if (w_we) r_mem[r_idx] <= w_wrec;
        if (w_emit) begin
            r_o_status <= w_emit_status;
            r_o_slot   <= w_emit_slot;
            r_o_handle <= w_emit_handle;
            r_o_last   <= w_emit_last;
        end
    end

    // Report status to the controller
    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.out_free   = !r_o_valid || i_out_ready;
        o_sts.div_done   = (r_dcnt == ptts_pkg::DIV_CNT_W'(ptts_pkg::DIV_STEPS));
        o_sts.idx_last   = (r_idx == LAST_IDX);
        o_sts.add_ok     = r_add_ok;
        o_sts.slot_ready = r_ready[r_idx];
        o_sts.more_ready = w_more;
        o_sts.res_last   = w_res_last;
    end

    assign o_out_valid       = r_o_valid;
    assign o_out_status      = ptts_pkg::STATUS_W'(r_o_status);
    assign o_out_slot        = r_o_slot;
    assign o_out_task_handle = r_o_handle;
    assign o_out_last        = r_o_last;

endmodule

FILE: design/periodic_task_tick_scheduler.sv
// Channel   Dir  Payload                                             Per request
// i_in      in   mode, handle, delay_time, period_time, target_slot  one request
// o_out     out  status, slot, task_handle, last                     1 to 8 results
//
// On add, delay and period are divided by the tick length with a
// reciprocal multiply, one 16-bit digit per cycle, then written to the slot.
// On tick, each slot is read from the single-port slot memory, then updated
// and written back the next cycle. Dispatch walks the same way and stops after
// its last result. Reset is synchronous and empties the table; a held result
// on o_out stalls the dispatch walk.
module periodic_task_tick_scheduler #(
    parameter int SLOTS       = ptts_pkg::SLOTS_DEF,
    parameter int TICK_LENGTH = ptts_pkg::TICK_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptts_in_if.sink     i_in,
    ptts_out_if.source  o_out
);

    ptts_pkg::t_dp_cmd w_cmd;
    ptts_pkg::t_dp_sts w_sts;

    // Sequence each request
    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Slot table, divider and result register
    ptts_dp #(
        .SLOTS       (SLOTS),
        .TICK_LENGTH (TICK_LENGTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_in_mode         (i_in.mode),
        .i_in_handle       (i_in.handle),
        .i_in_delay_time   (i_in.delay_time),
        .i_in_period_time  (i_in.period_time),
        .i_in_target_slot  (i_in.target_slot),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_out_status      (o_out.status),
        .o_out_slot        (o_out.slot),
        .o_out_task_handle (o_out.task_handle),
        .o_out_last        (o_out.last)
    );

endmodule

FILE: design/ptts_chk.sv
module ptts_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ptts_pkg::STATUS_W-1:0]   i_out_status,
    input logic [ptts_pkg::SLOT_W-1:0]     i_out_slot,
    input logic [ptts_pkg::HANDLE_W-1:0]   i_out_task_handle,
    input logic                            i_out_last
);

    // Busy right after taking a request
    ap_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted on two back-to-back cycles");

    // A dispatch stream in flight keeps the input closed
    ap_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input open while dispatch results are pending");

    // Only dispatch runs can have more than one result
    ap_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ptts_pkg::ST_RUN) |-> i_out_last)
        else $error("non-run result without last");

    // Handle only on run results
    ap_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ptts_pkg::ST_RUN) |-> (i_out_task_handle == '0))
        else $error("task handle set on a non-run result");

    // Stalled result holds
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_out_status, i_out_slot, i_out_task_handle, i_out_last}))
        else $error("stalled result changed");

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_slot        (o_out.slot),
    .i_out_task_handle (o_out.task_handle),
    .i_out_last        (o_out.last)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS           = ptts_pkg::SLOTS_DEF;
    localparam int TICK_LENGTH     = ptts_pkg::TICK_LENGTH_DEF;
    localparam int HANDLE_W        = ptts_pkg::HANDLE_W;
    localparam int TIME_W          = ptts_pkg::TIME_W;
    localparam int TGT_W           = ptts_pkg::TGT_W;
    localparam int SLOT_W          = ptts_pkg::SLOT_W;
    localparam int PEND_W          = ptts_pkg::PEND_W;
    localparam int MAX_RESULTS     = ptts_pkg::MAX_RESULTS;
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int RANDOM_REQUESTS = 66;
    localparam int SAT_TICKS       = 258;
    localparam int SAT_DISPATCHES  = 4;
    localparam int LONG_HOLD       = 400;
    localparam int HOLD_AFTER      = 120;
    localparam int DRAIN_CYCLES    = 60;
    localparam int MAX_REPORTS     = 10;

    localparam logic [TIME_W-1:0] TICK_DIV = TICK_LENGTH;

    typedef struct packed {
        ptts_pkg::t_mode     mode;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay_time;
        logic [TIME_W-1:0]   period_time;
        logic [TGT_W-1:0]    target_slot;
    } t_request;

    typedef struct packed {
        ptts_pkg::t_status   status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] task_handle;
        logic                last;
    } t_result;

    // Directed row: a request, plus a typed single result where it is obvious
    typedef struct packed {
        t_request          req;
        logic              typed;
        ptts_pkg::t_status status;
        logic [SLOT_W-1:0] slot;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{'{ptts_pkg::MODE_DISPATCH, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_NONE_READY, 3'd0},
        '{'{ptts_pkg::MODE_TICK, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF},
          1'b1, ptts_pkg::ST_TICK_DONE, 3'd0},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_DEL_IGNORED, 3'd0},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd15},
          1'b1, ptts_pkg::ST_DEL_IGNORED, 3'd0},
        '{'{ptts_pkg::MODE_ADD, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_ADDED, 3'd0},
        '{'{ptts_pkg::MODE_ADD, 16'hFFFF, 32'd9, 32'd10, 4'hF},
          1'b1, ptts_pkg::ST_ADDED, 3'd1},
        '{'{ptts_pkg::MODE_ADD, 16'h1234, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0},
          1'b1, ptts_pkg::ST_ADDED, 3'd2},
        '{'{ptts_pkg::MODE_ADD, 16'hA5A5, 32'd25, 32'd0, 4'd5},
          1'b1, ptts_pkg::ST_ADDED, 3'd3},
        '{'{ptts_pkg::MODE_ADD, 16'h5A5A, 32'd10, 32'd19, 4'd10},
          1'b1, ptts_pkg::ST_ADDED, 3'd4},
        '{'{ptts_pkg::MODE_ADD, 16'h8000, 32'd0, 32'd30, 4'd0},
          1'b1, ptts_pkg::ST_ADDED, 3'd5},
        '{'{ptts_pkg::MODE_ADD, 16'h7FFF, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_ADDED, 3'd6},
        '{'{ptts_pkg::MODE_ADD, 16'h0001, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_ADDED, 3'd7},
        '{'{ptts_pkg::MODE_ADD, 16'hCAFE, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_FULL, 3'd0},
        '{'{ptts_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_TICK_DONE, 3'd0},
        '{'{ptts_pkg::MODE_DISPATCH, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b0, ptts_pkg::ST_ADDED, 3'd0},
        '{'{ptts_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_TICK_DONE, 3'd0},
        '{'{ptts_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_TICK_DONE, 3'd0},
        '{'{ptts_pkg::MODE_DISPATCH, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b0, ptts_pkg::ST_ADDED, 3'd0},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd2},
          1'b1, ptts_pkg::ST_DELETED, 3'd2},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd2},
          1'b1, ptts_pkg::ST_DEL_IGNORED, 3'd0},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd8},
          1'b1, ptts_pkg::ST_DEL_IGNORED, 3'd0},
        '{'{ptts_pkg::MODE_ADD, 16'hBEEF, 32'd5, 32'd5, 4'd0},
          1'b0, ptts_pkg::ST_ADDED, 3'd0},
        '{'{ptts_pkg::MODE_DELETE, 16'h0000, 32'd0, 32'd0, 4'd4},
          1'b1, ptts_pkg::ST_DELETED, 3'd4},
        '{'{ptts_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b1, ptts_pkg::ST_TICK_DONE, 3'd0},
        '{'{ptts_pkg::MODE_DISPATCH, 16'h0000, 32'd0, 32'd0, 4'd0},
          1'b0, ptts_pkg::ST_ADDED, 3'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ptts_in_if  req_if ();
    ptts_out_if res_if ();

    periodic_task_tick_scheduler #(
        .SLOTS       (SLOTS),
        .TICK_LENGTH (TICK_LENGTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Task table as the scheduler should hold it
    logic                tbl_valid   [SLOTS];
    logic [HANDLE_W-1:0] tbl_handle  [SLOTS];
    logic [TIME_W-1:0]   tbl_delay   [SLOTS];
    logic [TIME_W-1:0]   tbl_period  [SLOTS];
    logic [PEND_W-1:0]   tbl_pending [SLOTS];

    t_result step_out    [MAX_RESULTS];
    t_result due_results [$];

    int  cycle_count     = 0;
    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  mode_seen [4]   = '{0, 0, 0, 0};
    int  full_bursts     = 0;
    int  full_table      = 0;
    int  sat_hits        = 0;
    bit  send_burst      = 1'b0;
    bit  sat_phase       = 1'b0;
    bit  long_hold_done  = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void free_entry(input int i);
        tbl_valid[i]   = 1'b0;
        tbl_handle[i]  = '0;
        tbl_delay[i]   = '0;
        tbl_period[i]  = '0;
        tbl_pending[i] = '0;
    endfunction

    // Apply one request to the task table; fill step_out, return result count
    function automatic int schedule_model(input t_request r);
        int n;
        bit placed;
        n = 0;
        placed = 1'b0;
        case (r.mode)
            ptts_pkg::MODE_ADD: begin
                step_out[0] = '{ptts_pkg::ST_FULL, '0, '0, 1'b1};
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !tbl_valid[i]) begin
                        tbl_valid[i]   = 1'b1;
                        tbl_handle[i]  = r.handle;
                        tbl_delay[i]   = r.delay_time / TICK_DIV;
                        tbl_period[i]  = r.period_time / TICK_DIV;
                        tbl_pending[i] = '0;
                        step_out[0]    = '{ptts_pkg::ST_ADDED, SLOT_W'(i), '0, 1'b1};
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    full_table++;
                n = 1;
            end
            ptts_pkg::MODE_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_delay[i] == 0) begin
                            // hold the run count at its ceiling
                            if (tbl_pending[i] != '1)
                                tbl_pending[i]++;
                            else
                                sat_hits++;
                            if (tbl_period[i] != 0)
                                tbl_delay[i] = tbl_period[i];
                        end else begin
                            tbl_delay[i]--;
                        end
                    end
                end
                step_out[0] = '{ptts_pkg::ST_TICK_DONE, '0, '0, 1'b1};
                n = 1;
            end
            ptts_pkg::MODE_DISPATCH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (n < MAX_RESULTS && tbl_valid[i] && tbl_pending[i] != 0) begin
                        step_out[n] = '{ptts_pkg::ST_RUN, SLOT_W'(i), tbl_handle[i], 1'b0};
                        n++;
                        tbl_pending[i]--;
                        // drop one-shot tasks once run
                        if (tbl_period[i] == 0)
                            free_entry(i);
                    end
                end
                if (n == MAX_RESULTS)
                    full_bursts++;
                if (n == 0) begin
                    step_out[0] = '{ptts_pkg::ST_NONE_READY, '0, '0, 1'b1};
                    n = 1;
                end
                step_out[n-1].last = 1'b1;
            end
            ptts_pkg::MODE_DELETE: begin
                if (r.target_slot < SLOTS && tbl_valid[r.target_slot]) begin
                    free_entry(int'(r.target_slot));
                    step_out[0] = '{ptts_pkg::ST_DELETED, SLOT_W'(r.target_slot), '0, 1'b1};
                end else begin
                    step_out[0] = '{ptts_pkg::ST_DEL_IGNORED, '0, '0, 1'b1};
                end
                n = 1;
            end
        endcase
        return n;
    endfunction

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t %s: expected status=%0d slot=%0d handle=%h last=%0d, ",
                      "got status=%0d slot=%0d handle=%h last=%0d"},
                     $time, what, want.status, want.slot, want.task_handle, want.last,
                     got.status, got.slot, got.task_handle, got.last);
    endfunction

    // Mostly short idle spans, now and then a long one
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(0, 99);
        r.mode = pick < 30 ? ptts_pkg::MODE_ADD : pick < 65 ? ptts_pkg::MODE_TICK :
                 pick < 88 ? ptts_pkg::MODE_DISPATCH : ptts_pkg::MODE_DELETE;
        r.handle = HANDLE_W'($urandom);
        pick = $urandom_range(0, 99);
        r.delay_time = pick < 70 ? TIME_W'($urandom_range(0, 40)) :
                       pick < 85 ? TIME_W'($urandom_range(0, 200)) : TIME_W'($urandom);
        pick = $urandom_range(0, 99);
        r.period_time = pick < 30 ? TIME_W'($urandom_range(0, 9)) :
                        pick < 75 ? TIME_W'($urandom_range(10, 60)) :
                        pick < 90 ? TIME_W'($urandom_range(61, 300)) : TIME_W'($urandom);
        r.target_slot = $urandom_range(0, 99) < 85 ? TGT_W'($urandom_range(0, 7)) :
                                                    TGT_W'($urandom_range(8, 15));
        return r;
    endfunction

    // Offer one request at the falling edge, hold it until taken
    task automatic send_request(input t_request r, input logic typed,
                                input ptts_pkg::t_status st,
                                input logic [SLOT_W-1:0] sl);
        int gap;
        int n;
        gap = (send_burst || $urandom_range(0, 99) < 55) ? 0 : pick_idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid       = 1'b1;
        req_if.mode        = r.mode;
        req_if.handle      = r.handle;
        req_if.delay_time  = r.delay_time;
        req_if.period_time = r.period_time;
        req_if.target_slot = r.target_slot;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        n = schedule_model(r);
        mode_seen[r.mode]++;
        if (typed) begin
            due_results.push_back('{st, sl, '0, 1'b1});
        end else begin
            for (int k = 0; k < n; k++)
                due_results.push_back(step_out[k]);
        end
    endtask

    // Compare each accepted result with the oldest one due
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{ptts_pkg::t_status'(res_if.status), res_if.slot, res_if.task_handle,
                    res_if.last};
            results_checked++;
            if (due_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.task_handle !== want.task_handle || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Result side: random stalls, calm windows, one long hold-off
    initial begin
        int stall_left;
        bit calm;
        stall_left = 0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
            end
            calm = sat_phase || (cycle_count % 3200 >= 2400);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                res_if.ready = 1'b0;
                stall_left = pick_idle_len() - 1;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Request side: reset, directed rows, random mix, saturation run
    initial begin
        t_request r;
        req_if.valid       = 1'b0;
        req_if.mode        = ptts_pkg::MODE_ADD;
        req_if.handle      = '0;
        req_if.delay_time  = '0;
        req_if.period_time = '0;
        req_if.target_slot = '0;
        for (int i = 0; i < SLOTS; i++)
            free_entry(i);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[k])
            send_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed,
                         DIRECTED_ROWS[k].status, DIRECTED_ROWS[k].slot);

        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 60 == 0)
                send_burst = ($urandom_range(0, 2) == 0);
            send_request(random_request(), 1'b0, ptts_pkg::ST_ADDED, '0);
        end

        // Empty the table, fill it with zero-delay tasks, tick the one-shot
        // tasks past the run-count ceiling
        send_burst = 1'b1;
        sat_phase  = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            r = random_request();
            r.mode = ptts_pkg::MODE_DELETE;
            r.target_slot = TGT_W'(s);
            send_request(r, 1'b0, ptts_pkg::ST_ADDED, '0);
        end
        for (int s = 0; s <= SLOTS; s++) begin
            r = random_request();
            r.mode = ptts_pkg::MODE_ADD;
            r.delay_time = TIME_W'($urandom_range(0, TICK_LENGTH - 1));
            r.period_time = (s % 2 == 0) ? TICK_DIV : '0;
            if (s < SLOTS)
                send_request(r, 1'b1, ptts_pkg::ST_ADDED, SLOT_W'(s));
            else
                send_request(r, 1'b1, ptts_pkg::ST_FULL, '0);
        end
        repeat (SAT_TICKS) begin
            r = random_request();
            r.mode = ptts_pkg::MODE_TICK;
            send_request(r, 1'b1, ptts_pkg::ST_TICK_DONE, '0);
        end
        // Dispatch from the loaded table: one full burst, then the periodic ones
        repeat (SAT_DISPATCHES) begin
            r = random_request();
            r.mode = ptts_pkg::MODE_DISPATCH;
            send_request(r, 1'b0, ptts_pkg::ST_ADDED, '0);
        end
        sat_phase = 1'b0;

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: add %0d, tick %0d, dispatch %0d, delete %0d",
                 mode_seen[ptts_pkg::MODE_ADD] + mode_seen[ptts_pkg::MODE_TICK] +
                 mode_seen[ptts_pkg::MODE_DISPATCH] + mode_seen[ptts_pkg::MODE_DELETE],
                 mode_seen[ptts_pkg::MODE_ADD], mode_seen[ptts_pkg::MODE_TICK],
                 mode_seen[ptts_pkg::MODE_DISPATCH], mode_seen[ptts_pkg::MODE_DELETE]);
        $display({"%0d results checked, %0d full-table adds, %0d eight-run dispatches, ",
                  "%0d capped run counts, %0d mismatches"},
                 results_checked, full_table, full_bursts, sat_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
